[design/lcfp_pkg.sv]
// ----------------------------------------------------------------------------
// Lift command frame parser package
// Header bytes, status codes and the result record shared across the block.
// ----------------------------------------------------------------------------
package lcfp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;

	localparam int FRAME_FIELDS = 5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOHDR  = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;
	localparam logic [1:0] ST_BADSUM = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] from_floor;
		logic [7:0] to_floor;
		logic [7:0] command_code;
		logic [7:0] car_number;
		logic [7:0] vehicle_number;
	} result_t;

endpackage

[design/lcfp_if.sv]
// ----------------------------------------------------------------------------
// Lift command frame parser channels
// Valid/ready channels for received bytes and for frame reports.
// ----------------------------------------------------------------------------
interface lcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lcfp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] from_floor;
	logic [7:0] to_floor;
	logic [7:0] command_code;
	logic [7:0] car_number;
	logic [7:0] vehicle_number;

	modport source (output valid, output status, output from_floor, output to_floor,
		output command_code, output car_number, output vehicle_number, input ready);
	modport sink   (input valid, input status, input from_floor, input to_floor,
		input command_code, input car_number, input vehicle_number, output ready);
endinterface

[design/lcfp_parse_core.sv]
// ----------------------------------------------------------------------------
// Lift command frame parser core
// Header hunt, field capture and checksum state, updated once per step.
// ----------------------------------------------------------------------------
module lcfp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                res_valid,
	output lcfp_pkg::result_t   res
);

	localparam logic [3:0] PH_HUNT   = 4'd0;
	localparam logic [3:0] PH_GOT_AA = 4'd1;
	localparam logic [3:0] PH_FIELD0 = 4'd2;
	localparam logic [3:0] PH_FIELD4 = 4'd6;
	localparam logic [3:0] PH_CHECK  = 4'd7;
	localparam logic [3:0] PH_DONE   = 4'd8;

	logic [3:0] phase_q;
	logic [7:0] sum_q;
	logic [7:0] field_q [lcfp_pkg::FRAME_FIELDS];

	logic [3:0] phase_d;
	logic [3:0] phase_mid;
	logic [7:0] sum_d;
	logic       capture;
	logic [2:0] field_idx;

	assign field_idx = 3'(phase_q - PH_FIELD0);

	always_comb begin
		phase_mid = phase_q;
		sum_d     = sum_q;
		capture   = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q) inside
			PH_HUNT: begin
				if (data_byte == lcfp_pkg::HDR_FIRST)
					phase_mid = PH_GOT_AA;
			end
			PH_GOT_AA: begin
				if (data_byte == lcfp_pkg::HDR_SECOND) begin
					phase_mid = PH_FIELD0;
					sum_d     = lcfp_pkg::HDR_FIRST + lcfp_pkg::HDR_SECOND;
				end else if (data_byte != lcfp_pkg::HDR_FIRST) begin
					phase_mid = PH_HUNT;
				end
			end
			[PH_FIELD0:PH_FIELD4]: begin
				capture   = 1'b1;
				sum_d     = sum_q + data_byte;
				phase_mid = phase_q + 4'd1;
			end
			PH_CHECK: begin
				res_valid = 1'b1;
				phase_mid = PH_DONE;
				if (data_byte == sum_q) begin
					res.status         = lcfp_pkg::ST_OK;
					res.from_floor     = field_q[0];
					res.to_floor       = field_q[1];
					res.command_code   = field_q[2];
					res.car_number     = field_q[3];
					res.vehicle_number = field_q[4];
				end else begin
					res.status = lcfp_pkg::ST_BADSUM;
				end
			end
			default: begin
				// reported: ignore until the end of the buffer
			end
		endcase

		phase_d = phase_mid;
		if (last_byte) begin
			// report an unfinished frame, then start over
			if (!res_valid && phase_mid < PH_DONE) begin
				res_valid  = 1'b1;
				res.status = (phase_mid < PH_FIELD0) ? lcfp_pkg::ST_NOHDR
					: lcfp_pkg::ST_SHORT;
			end
			phase_d = PH_HUNT;
			sum_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
		end
	end

	// every field is rewritten after each header before an OK report reads it, so no reset is needed
	always_ff @(posedge clk) begin
		if (step && capture)
			field_q[field_idx] <= data_byte;
	end

endmodule

[design/lift_command_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// Lift command frame parser
// Byte stream in, one status report per buffer out.
// ----------------------------------------------------------------------------
// Path: the byte that causes a report is held in the input register, and the
// report is then captured in the result register, which drives the output.
// Throughput: one byte per cycle, unless a waiting report stalls on reports.ready.
// Reset: arst_n clears both pipeline valids and puts the parser back to
// hunting for the header with a zero running sum.
module lift_command_frame_parser_top (
	input  logic                 clk,
	input  logic                 arst_n,
	lcfp_byte_if.sink            bytes,
	lcfp_result_if.source        reports
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              valid_s2;
	lcfp_pkg::result_t res_s2;

	logic              advance;
	logic              core_valid;
	lcfp_pkg::result_t core_res;

	// the byte in stage one moves on once the result register can take it
	assign advance     = valid_s1 && (!valid_s2 || reports.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	lcfp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= core_valid;
		end else if (reports.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid)
			res_s2 <= core_res;
	end

	assign reports.valid          = valid_s2;
	assign reports.status         = res_s2.status;
	assign reports.from_floor     = res_s2.from_floor;
	assign reports.to_floor       = res_s2.to_floor;
	assign reports.command_code   = res_s2.command_code;
	assign reports.car_number     = res_s2.car_number;
	assign reports.vehicle_number = res_s2.vehicle_number;

endmodule

[verif/lift_command_frame_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// Lift command frame parser testbench
// Sends byte buffers (clean frames, broken frames, noise) through the byte
// channel. A scoreboard tracks the header hunt, the field capture and the
// running sum, and expects one report per buffer. Both channels idle and stall
// at random, with one long stretch of back-to-back transfers.
// ----------------------------------------------------------------------------
module lift_command_frame_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 500;
	localparam int BURST_ITEMS  = 120;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] octets_t[$];

	class frame_report_board;
		typedef enum logic [2:0] {SEEK_AA, SEEK_55, IN_FIELDS, IN_CHECK, SKIPPING} hunt_t;

		hunt_t              phase;
		logic [7:0]         frame_sum;
		logic [7:0]         fields[lcfp_pkg::FRAME_FIELDS];
		int                 field_idx;
		lcfp_pkg::result_t  pending[$];
		int                 fails;

		function new();
			fails = 0;
			clear();
		endfunction

		function void clear();
			phase = SEEK_AA;
			frame_sum = '0;
			field_idx = 0;
			foreach (fields[k])
				fields[k] = '0;
		endfunction

		// Advance the frame state by one transferred byte; queue any report.
		function void note_byte(logic [7:0] b, logic last);
			lcfp_pkg::result_t rep;
			bit                made;
			rep = '0;
			made = 1'b0;
			case (phase)
				SEEK_AA: begin
					if (b == lcfp_pkg::HDR_FIRST)
						phase = SEEK_55;
				end
				SEEK_55: begin
					if (b == lcfp_pkg::HDR_SECOND) begin
						phase = IN_FIELDS;
						field_idx = 0;
						frame_sum = lcfp_pkg::HDR_FIRST + lcfp_pkg::HDR_SECOND;
					end else if (b != lcfp_pkg::HDR_FIRST) begin
						phase = SEEK_AA;
					end
				end
				IN_FIELDS: begin
					fields[field_idx] = b;
					frame_sum = frame_sum + b;
					field_idx++;
					if (field_idx == lcfp_pkg::FRAME_FIELDS)
						phase = IN_CHECK;
				end
				IN_CHECK: begin
					if (b == frame_sum) begin
						rep.status = lcfp_pkg::ST_OK;
						rep.from_floor = fields[0];
						rep.to_floor = fields[1];
						rep.command_code = fields[2];
						rep.car_number = fields[3];
						rep.vehicle_number = fields[4];
					end else begin
						rep.status = lcfp_pkg::ST_BADSUM;
					end
					made = 1'b1;
					phase = SKIPPING;
				end
				default: ;
			endcase
			if (last) begin
				if (!made && phase != SKIPPING) begin
					rep.status = (phase == SEEK_AA || phase == SEEK_55)
						? lcfp_pkg::ST_NOHDR : lcfp_pkg::ST_SHORT;
					made = 1'b1;
				end
				clear();
			end
			if (made)
				pending = {pending, rep};
		endfunction

		function void match_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
				fails++;
			end
		endfunction

		function void check_report(lcfp_pkg::result_t got);
			lcfp_pkg::result_t want;
			if (pending.size() == 0) begin
				$error("unexpected report: status %0d", got.status);
				fails++;
				return;
			end
			want = pending.pop_front();
			match_field("status", 8'(want.status), 8'(got.status));
			match_field("from_floor", want.from_floor, got.from_floor);
			match_field("to_floor", want.to_floor, got.to_floor);
			match_field("command_code", want.command_code, got.command_code);
			match_field("car_number", want.car_number, got.car_number);
			match_field("vehicle_number", want.vehicle_number, got.vehicle_number);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;

	frame_report_board board = new();

	lcfp_byte_if   bytes_ch();
	lcfp_result_if reports_ch();

	lift_command_frame_parser_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.reports (reports_ch)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		reports_ch.ready <= !(idle_on && $urandom_range(99) < 34);
	end

	always @(posedge clk) begin : report_monitor
		lcfp_pkg::result_t got;
		if (arst_n && reports_ch.valid && reports_ch.ready) begin
			got.status = reports_ch.status;
			got.from_floor = reports_ch.from_floor;
			got.to_floor = reports_ch.to_floor;
			got.command_code = reports_ch.command_code;
			got.car_number = reports_ch.car_number;
			got.vehicle_number = reports_ch.vehicle_number;
			board.check_report(got);
		end
	end

	// End the run once neither channel has seen a transfer for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((bytes_ch.valid && bytes_ch.ready) || (reports_ch.valid && reports_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_octet(logic [7:0] b, logic last);
		while (idle_on && $urandom_range(99) < 34) begin
			bytes_ch.valid <= 1'b0;
			@(negedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		bytes_ch.last_byte <= last;
		@(posedge clk);
		while (!bytes_ch.ready)
			@(posedge clk);
		board.note_byte(b, last);
		@(negedge clk);
	endtask

	task automatic send_buffer(octets_t octs);
		foreach (octs[k])
			send_octet(octs[k], k == octs.size() - 1);
	endtask

	function automatic octets_t frame_of(logic [7:0] fill[lcfp_pkg::FRAME_FIELDS], bit good);
		octets_t    fr;
		logic [7:0] sum;
		fr = {lcfp_pkg::HDR_FIRST, lcfp_pkg::HDR_SECOND};
		sum = lcfp_pkg::HDR_FIRST + lcfp_pkg::HDR_SECOND;
		foreach (fill[k]) begin
			fr = {fr, fill[k]};
			sum = sum + fill[k];
		end
		// Flip one bit to break the checksum.
		if (!good)
			sum = sum ^ (8'h01 << $urandom_range(7));
		fr = {fr, sum};
		return fr;
	endfunction

	function automatic logic [7:0] noise_octet();
		case ($urandom_range(3))
			0: return lcfp_pkg::HDR_FIRST;
			1: return lcfp_pkg::HDR_SECOND;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Build one random buffer; counted excludes bytes sent after the report.
	task automatic make_buffer(output octets_t octs, output int counted);
		int         kind;
		int         keep;
		int         tail;
		logic [7:0] fill[lcfp_pkg::FRAME_FIELDS];
		octets_t    fr;
		octs = {};
		kind = $urandom_range(99);
		repeat ($urandom_range(2))
			octs = {octs, noise_octet()};
		if (kind < 15) begin
			repeat ($urandom_range(1, 6))
				octs = {octs, noise_octet()};
			counted = octs.size();
		end else begin
			if ($urandom_range(3) == 0)
				octs = {octs, lcfp_pkg::HDR_FIRST};
			foreach (fill[k])
				fill[k] = 8'($urandom_range(255));
			fr = frame_of(fill, $urandom_range(3) != 0);
			// Cut the frame before its checksum byte.
			if (kind < 35) begin
				keep = $urandom_range(1, 7);
				while (fr.size() > keep)
					void'(fr.pop_back());
			end
			foreach (fr[k])
				octs = {octs, fr[k]};
			counted = octs.size();
			tail = (kind < 35) ? 0 : $urandom_range(3);
			repeat (tail)
				octs = {octs, 8'($urandom_range(255))};
		end
	endtask

	initial begin : stimulus
		logic [7:0] fill[lcfp_pkg::FRAME_FIELDS];
		octets_t    octs;
		int         sent;
		int         counted;

		arst_n = 1'b0;
		idle_on = 1'b1;
		bytes_ch.valid = 1'b0;
		bytes_ch.data_byte = '0;
		bytes_ch.last_byte = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single zero byte, then a lone AA at the buffer end: no header.
		send_buffer({8'h00});
		send_buffer({lcfp_pkg::HDR_FIRST});
		// Header alone, buffer ends before any field: short frame.
		send_buffer({lcfp_pkg::HDR_FIRST, lcfp_pkg::HDR_SECOND});
		// Repeated AA, all-ones fields, checksum byte closes the buffer.
		foreach (fill[k])
			fill[k] = 8'hFF;
		octs = frame_of(fill, 1'b1);
		octs.push_front(lcfp_pkg::HDR_FIRST);
		send_buffer(octs);
		// Bad checksum on all-zero fields, then bytes that must be ignored.
		foreach (fill[k])
			fill[k] = 8'h00;
		octs = frame_of(fill, 1'b0);
		octs = {octs, 8'hFF};
		octs = {octs, lcfp_pkg::HDR_FIRST};
		send_buffer(octs);
		// Noise before the header, cut off inside the fields.
		send_buffer({8'h12, lcfp_pkg::HDR_FIRST, lcfp_pkg::HDR_SECOND, 8'h01});

		sent = 0;
		idle_on = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= BURST_ITEMS)
				idle_on = 1'b1;
			make_buffer(octs, counted);
			send_buffer(octs);
			sent += counted;
		end
		bytes_ch.valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.fails == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
design/lcfp_pkg.sv
design/lcfp_if.sv
design/lcfp_parse_core.sv
design/lift_command_frame_parser_top.sv
verif/lift_command_frame_parser_top_tb.sv
